// ===== hdl/i2ctbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C target byte engine package
// Shared command codes, bus phases, configuration and result types.
// ----------------------------------------------------------------------------
package i2ctbe_pkg;

    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_SHIFT    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_LOAD     = 3'd3,
        CMD_SET_LEN  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_WR_ACK  = 3'd2,
        PH_WR_DATA = 3'd3,
        PH_RD_ACK  = 3'd4,
        PH_RD_DATA = 3'd5
    } t_phase;

    localparam int unsigned CFG_IDX_OWN_ADDR = 0;
    localparam int unsigned CFG_IDX_WR_CAP   = 1;

    localparam logic [7:0] ACK_BYTE   = 8'h7F;
    localparam logic [7:0] IDLE_BYTE  = 8'hFF;
    localparam logic [7:0] GCALL_ADDR = 8'h00;
    localparam logic [5:0] POS_MAX    = 6'd63;
    localparam logic [5:0] WR_CAP_RST = 6'd32;

    typedef struct packed {
        logic [6:0] own_address;
        logic [5:0] write_capacity;
    } t_cfg;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       short_phase;
        logic       engaged;
        logic       wr_valid;
        logic [7:0] wr_byte;
        logic [4:0] wr_index;
        logic       msg_done;
        logic [5:0] msg_len;
    } t_result;

endpackage

// ===== hdl/i2c_target_byte_engine_core.sv =====
// ----------------------------------------------------------------------------
// I2C target byte engine core
// Byte-level I2C target sequencer with a read byte store and result pipeline.
// ----------------------------------------------------------------------------
// Usage: bus events and host requests enter on the s_axis channel, one request
// per cycle while not stalled; tuser carries the command and tdata its operands.
// Every accepted request gives exactly one result on m_axis, in order: the next
// shift byte, the phase length, the engaged flag, any received write byte and
// any completed write message.
// An accepted request is registered in the store stage, together with the
// registered read data of the read store access, and then in the output
// register. Throughput is one request per cycle while the output is not held,
// as the phase and position registers update on each accepted request.
// A load and a later read of the read store are always at least one request
// apart, so the write has landed before the read port samples the entry.
// When the receiver stalls, results collect in the store stage and the output
// register; the input keeps accepting while either has room.
// Reset clears the phase, positions, read length and configuration (own
// address 0, write capacity 32). The read store is not cleared and holds
// nothing meaningful until loaded.
// ----------------------------------------------------------------------------
module i2c_target_byte_engine_core #(
    parameter int unsigned READ_DEPTH  = 32,
    parameter int unsigned WRITE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // shift_byte[7:0], host_index[12:8], host_byte[20:13], host_length[26:21]
    input  logic [31:0] s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], short_phase[8], engaged[9], wr_valid[10], wr_byte[18:11],
    // wr_index[23:19], msg_done[24], msg_len[30:25]
    output logic [31:0] m_axis_tdata
);
    import i2ctbe_pkg::*;

    localparam int unsigned AW = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1;

    logic          s_acc, s1_adv;
    t_result       seq_res, r_s1_res, r_out, s1_merged;
    logic          seq_use_mem, r_s1_use_mem, r_s1_valid, r_out_valid;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data, rd_data;

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_s1_valid || s1_adv);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    i2ctbe_seq #(
        .READ_DEPTH  (READ_DEPTH),
        .WRITE_DEPTH (WRITE_DEPTH),
        .AW          (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req         (s_acc),
        .i_cmd         (t_cmd'(s_axis_tuser)),
        .i_shift_byte  (s_axis_tdata[7:0]),
        .i_host_index  (s_axis_tdata[12:8]),
        .i_host_byte   (s_axis_tdata[20:13]),
        .i_host_length (s_axis_tdata[26:21]),
        .o_res         (seq_res),
        .o_use_mem     (seq_use_mem),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    i2ctbe_rstore #(
        .DEPTH (READ_DEPTH),
        .AW    (AW)
    ) u_rstore (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        s1_merged = r_s1_res;
        if (r_s1_use_mem) begin
            s1_merged.tx_byte = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_res     <= seq_res;
            r_s1_use_mem <= seq_use_mem;
        end
        if (s1_adv) begin
            r_out <= s1_merged;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.msg_len, r_out.msg_done, r_out.wr_index,
                            r_out.wr_byte, r_out.wr_valid, r_out.engaged,
                            r_out.short_phase, r_out.tx_byte};

`ifndef SYNTHESIS
    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_s1_valid)
        else $error("accepted request did not reach the store stage");

    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both result stages are held");

    a_msg_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.msg_done) |-> (r_out.msg_len != 6'd0))
        else $error("completed message reported with zero length");

    a_wr_msg_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.wr_valid && r_out.msg_done))
        else $error("write byte and message close in one result");

    a_released_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.engaged) |-> !r_out.short_phase)
        else $error("released engine reports a short phase");
`endif

endmodule

// ===== hdl/i2ctbe_rstore.sv =====
// ----------------------------------------------------------------------------
// I2C target byte engine read store
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module i2ctbe_rstore #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds until the next read, so a stalled result keeps it.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/i2ctbe_seq.sv =====
// ----------------------------------------------------------------------------
// I2C target byte engine sequencer
// Bus phase tracking, position counters, configuration and per-request result.
// ----------------------------------------------------------------------------
module i2ctbe_seq #(
    parameter int unsigned READ_DEPTH  = 32,
    parameter int unsigned WRITE_DEPTH = 32,
    parameter int unsigned AW          = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    input  logic                 i_req,
    input  i2ctbe_pkg::t_cmd     i_cmd,
    input  logic [7:0]           i_shift_byte,
    input  logic [4:0]           i_host_index,
    input  logic [7:0]           i_host_byte,
    input  logic [5:0]           i_host_length,
    output i2ctbe_pkg::t_result  o_res,
    output logic                 o_use_mem,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [7:0]           o_wr_data
);
    import i2ctbe_pkg::*;

    localparam logic [8:0] RD_LIM = 9'(READ_DEPTH);
    localparam logic [5:0] WD_LIM = (WRITE_DEPTH > 63) ? 6'd63 : 6'(WRITE_DEPTH);

    t_cfg       r_cfg;
    t_phase     r_phase, n_phase;
    logic       r_start_seen, n_start_seen;
    logic [5:0] r_write_pos, n_write_pos;
    logic [5:0] r_read_pos, n_read_pos;
    logic [5:0] r_read_len, n_read_len;

    logic       is_start, is_shift, is_stop, is_load, is_len;
    logic       addr_match, close_msg, close_active;
    logic       rd_go, wr_go, wr_last, rd_last, rd_in_range;
    logic [5:0] cap, wp_inc, rp_inc;
    logic [7:0] rp_ext, hi_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address    <= '0;
            r_cfg.write_capacity <= WR_CAP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(CFG_IDX_OWN_ADDR)) begin
                r_cfg.own_address <= i_cfg_data;
            end else begin
                r_cfg.write_capacity <= i_cfg_data[5:0];
            end
        end
    end

    assign is_start = (i_cmd == CMD_START);
    assign is_shift = (i_cmd == CMD_SHIFT);
    assign is_stop  = (i_cmd == CMD_STOP);
    assign is_load  = (i_cmd == CMD_LOAD);
    assign is_len   = (i_cmd == CMD_SET_LEN);

    assign addr_match = (i_shift_byte == GCALL_ADDR) ||
                        (i_shift_byte[7:1] == r_cfg.own_address);
    assign close_msg  = (is_shift && r_phase == PH_ADDR && addr_match) ||
                        (is_stop && r_start_seen);
    assign close_active = close_msg && (r_write_pos != 6'd0);

    // A message close clears the read length before the read request is judged.
    assign rd_go = addr_match && i_shift_byte[0] && !close_active && (r_read_len != 6'd0);
    assign wr_go = addr_match && !i_shift_byte[0] && (r_cfg.write_capacity != 6'd0);

    assign cap     = (r_cfg.write_capacity < WD_LIM) ? r_cfg.write_capacity : WD_LIM;
    assign wp_inc  = (r_write_pos < POS_MAX) ? r_write_pos + 6'd1 : r_write_pos;
    assign rp_inc  = (r_read_pos < POS_MAX) ? r_read_pos + 6'd1 : r_read_pos;
    assign wr_last = (wp_inc >= cap);
    assign rd_last = (rp_inc >= r_read_len);
    assign rd_in_range = (r_read_pos < r_read_len) && ({3'b000, r_read_pos} < RD_LIM);

    assign rp_ext = {2'b00, r_read_pos};
    assign hi_ext = {3'b000, i_host_index};

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_start_seen = r_start_seen;
        n_write_pos  = r_write_pos;
        n_read_pos   = r_read_pos;
        n_read_len   = r_read_len;
        if (is_start) begin
            n_start_seen = 1'b1;
            n_phase      = PH_ADDR;
        end else if (is_shift) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (rd_go) begin
                        n_phase = PH_RD_ACK;
                    end else if (wr_go) begin
                        n_phase = PH_WR_ACK;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_WR_ACK:  n_phase = PH_WR_DATA;
                PH_WR_DATA: begin
                    n_write_pos = wp_inc;
                    n_phase     = wr_last ? PH_IDLE : PH_WR_ACK;
                end
                PH_RD_ACK:  n_phase = i_shift_byte[0] ? PH_IDLE : PH_RD_DATA;
                PH_RD_DATA: begin
                    n_read_pos = rp_inc;
                    n_phase    = rd_last ? PH_IDLE : PH_RD_ACK;
                end
                default:    n_phase = PH_IDLE;
            endcase
        end else if (is_stop && r_start_seen) begin
            n_start_seen = 1'b0;
            n_phase      = PH_IDLE;
        end else if (is_len) begin
            n_read_len = i_host_length;
            n_read_pos = 6'd0;
        end
        if (close_active) begin
            n_read_len  = 6'd0;
            n_write_pos = 6'd0;
        end
    end

    // Result of the request.
    always_comb begin
        o_res             = '0;
        o_res.tx_byte     = IDLE_BYTE;
        o_res.engaged     = (r_phase != PH_IDLE);
        o_use_mem         = 1'b0;
        if (is_start) begin
            o_res.engaged = 1'b1;
        end else if (is_shift) begin
            o_res.engaged = 1'b0;
            unique case (r_phase)
                PH_ADDR: begin
                    if (rd_go || wr_go) begin
                        o_res.tx_byte     = ACK_BYTE;
                        o_res.short_phase = 1'b1;
                        o_res.engaged     = 1'b1;
                    end
                end
                PH_WR_ACK: o_res.engaged = 1'b1;
                PH_WR_DATA: begin
                    o_res.wr_valid = 1'b1;
                    o_res.wr_byte  = i_shift_byte;
                    o_res.wr_index = r_write_pos[4:0];
                    if (!wr_last) begin
                        o_res.tx_byte     = ACK_BYTE;
                        o_res.short_phase = 1'b1;
                        o_res.engaged     = 1'b1;
                    end
                end
                PH_RD_ACK: begin
                    if (!i_shift_byte[0]) begin
                        o_res.engaged = 1'b1;
                        o_use_mem     = rd_in_range;
                    end
                end
                PH_RD_DATA: begin
                    if (!rd_last) begin
                        o_res.short_phase = 1'b1;
                        o_res.engaged     = 1'b1;
                    end
                end
                default: o_res.engaged = 1'b0;
            endcase
        end else if (is_stop && r_start_seen) begin
            o_res.engaged = 1'b0;
        end
        if (close_active) begin
            o_res.msg_done = 1'b1;
            o_res.msg_len  = r_write_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_start_seen <= 1'b0;
            r_write_pos  <= '0;
            r_read_pos   <= '0;
            r_read_len   <= '0;
        end else if (i_req) begin
            r_phase      <= n_phase;
            r_start_seen <= n_start_seen;
            r_write_pos  <= n_write_pos;
            r_read_pos   <= n_read_pos;
            r_read_len   <= n_read_len;
        end
    end

    assign o_rd_en   = i_req && o_use_mem;
    assign o_rd_addr = rp_ext[AW-1:0];
    assign o_wr_en   = i_req && is_load && ({1'b0, hi_ext} < RD_LIM);
    assign o_wr_addr = hi_ext[AW-1:0];
    assign o_wr_data = i_host_byte;

endmodule

// ===== verif/i2c_target_byte_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// I2C target byte engine core testbench
// Drives bus events and host requests into the stream input and predicts
// every result in step with the traffic. Each result that leaves the block is
// checked field by field against the oldest prediction. Directed sequences
// come first, then random bus transfers under several register settings.
// ----------------------------------------------------------------------------
module i2c_target_byte_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2ctbe_pkg::*;

    localparam int READ_DEPTH     = 32;
    localparam int WRITE_DEPTH    = 32;
    localparam int RESULT_LATENCY = 2;
    localparam int STALL_LIMIT    = 2000;
    localparam int IDLE_PERCENT   = 31;
    localparam int PHASE_ITEMS    = 300;

    // Command codes the block does not know; it must ignore them.
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;
    localparam logic BUS_ACK  = 1'b0;
    localparam logic BUS_NACK = 1'b1;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] shift_byte;
        logic [4:0] host_index;
        logic [7:0] host_byte;
        logic [5:0] host_length;
    } t_bus_req;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [6:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Mirror of the engine state, advanced once per accepted request.
    logic [6:0]  own_addr    = '0;
    logic [5:0]  wr_cap      = WR_CAP_RST;
    t_phase      bus_phase   = PH_IDLE;
    logic        start_seen  = 1'b0;
    logic [5:0]  wpos        = '0;
    logic [5:0]  rpos        = '0;
    logic [5:0]  rlen        = '0;
    logic [7:0]  rd_store [READ_DEPTH];

    t_result     due_outputs [$];
    int          n_sent      = 0;
    int          n_errors    = 0;
    int          quiet_cycles = 0;
    bit          no_idle     = 1'b0;

    i2c_target_byte_engine_core #(
        .READ_DEPTH  (READ_DEPTH),
        .WRITE_DEPTH (WRITE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // Engine prediction
    // ------------------------------------------------------------------
    function automatic void release_bus(inout t_result res);
        bus_phase       = PH_IDLE;
        res.tx_byte     = IDLE_BYTE;
        res.short_phase = 1'b0;
        res.engaged     = 1'b0;
    endfunction

    function automatic void enter_phase(input t_phase nxt, input logic [7:0] tx,
                                        input logic shortp, inout t_result res);
        bus_phase       = nxt;
        res.tx_byte     = tx;
        res.short_phase = shortp;
        res.engaged     = 1'b1;
    endfunction

    function automatic void close_message(inout t_result res);
        if (wpos != '0) begin
            res.msg_done = 1'b1;
            res.msg_len  = wpos;
            rlen         = '0;
            wpos         = '0;
        end
    endfunction

    function automatic t_result engine_outputs(input t_bus_req r);
        t_result    res;
        logic [7:0] b;
        logic       hit;
        int         cap;
        res         = '0;
        res.tx_byte = IDLE_BYTE;
        res.engaged = (bus_phase != PH_IDLE);
        b           = r.shift_byte;
        case (r.cmd)
            CMD_START: begin
                start_seen = 1'b1;
                enter_phase(PH_ADDR, IDLE_BYTE, 1'b0, res);
            end
            CMD_SHIFT: begin
                case (bus_phase)
                    PH_ADDR: begin
                        hit = (b == GCALL_ADDR) || (b[7:1] == own_addr);
                        // A pending write message is closed before the new
                        // direction is looked at, so it may clear the length.
                        if (hit)
                            close_message(res);
                        if (hit && b[0] == RW_READ && rlen != '0)
                            enter_phase(PH_RD_ACK, ACK_BYTE, 1'b1, res);
                        else if (hit && b[0] == RW_WRITE && wr_cap != '0)
                            enter_phase(PH_WR_ACK, ACK_BYTE, 1'b1, res);
                        else
                            release_bus(res);
                    end
                    PH_WR_ACK: enter_phase(PH_WR_DATA, IDLE_BYTE, 1'b0, res);
                    PH_WR_DATA: begin
                        res.wr_valid = 1'b1;
                        res.wr_byte  = b;
                        res.wr_index = wpos[4:0];
                        cap = (wr_cap < WRITE_DEPTH) ? wr_cap : WRITE_DEPTH;
                        if (wpos != POS_MAX)
                            wpos++;
                        if (wpos >= cap)
                            release_bus(res);
                        else
                            enter_phase(PH_WR_ACK, ACK_BYTE, 1'b1, res);
                    end
                    PH_RD_ACK: begin
                        if (b[0] == BUS_NACK)
                            release_bus(res);
                        else if (rpos < rlen && rpos < READ_DEPTH)
                            enter_phase(PH_RD_DATA, rd_store[rpos[4:0]], 1'b0, res);
                        else
                            enter_phase(PH_RD_DATA, IDLE_BYTE, 1'b0, res);
                    end
                    PH_RD_DATA: begin
                        if (rpos != POS_MAX)
                            rpos++;
                        if (rpos >= rlen)
                            release_bus(res);
                        else
                            enter_phase(PH_RD_ACK, IDLE_BYTE, 1'b1, res);
                    end
                    default: release_bus(res);
                endcase
            end
            CMD_STOP: begin
                if (start_seen) begin
                    start_seen = 1'b0;
                    release_bus(res);
                    close_message(res);
                end
            end
            CMD_LOAD: begin
                if (r.host_index < READ_DEPTH)
                    rd_store[r.host_index] = r.host_byte;
            end
            CMD_SET_LEN: begin
                rlen = r.host_length;
                rpos = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_outputs.size() == 0) begin
                $error("result 0x%0h arrived with no request outstanding", m_axis_tdata);
                n_errors++;
            end else begin
                want = due_outputs.pop_front();
                check_field("tx_byte",     want.tx_byte,     m_axis_tdata[7:0]);
                check_field("short_phase", want.short_phase, m_axis_tdata[8]);
                check_field("engaged",     want.engaged,     m_axis_tdata[9]);
                check_field("wr_valid",    want.wr_valid,    m_axis_tdata[10]);
                check_field("wr_byte",     want.wr_byte,     m_axis_tdata[18:11]);
                check_field("wr_index",    want.wr_index,    m_axis_tdata[23:19]);
                check_field("msg_done",    want.msg_done,    m_axis_tdata[24]);
                check_field("msg_len",     want.msg_len,     m_axis_tdata[30:25]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** i2c_target_byte_engine_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------
    task automatic send_req(input t_bus_req r);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {5'd0, r.host_length, r.host_byte, r.host_index, r.shift_byte};
        do @(posedge i_clk); while (!s_axis_tready);
        due_outputs.push_back(engine_outputs(r));
        n_sent++;
    endtask

    // Operand fields that a command ignores still carry random values.
    task automatic bus_event(input logic [2:0] cmd, input logic [7:0] sb);
        t_bus_req r;
        r.cmd         = cmd;
        r.shift_byte  = sb;
        r.host_index  = 5'($urandom);
        r.host_byte   = 8'($urandom);
        r.host_length = 6'($urandom_range(0, READ_DEPTH));
        send_req(r);
    endtask

    task automatic load_byte(input logic [4:0] idx, input logic [7:0] value);
        t_bus_req r;
        r.cmd         = CMD_LOAD;
        r.shift_byte  = 8'($urandom);
        r.host_index  = idx;
        r.host_byte   = value;
        r.host_length = 6'($urandom_range(0, READ_DEPTH));
        send_req(r);
    endtask

    task automatic set_read_len(input logic [5:0] len);
        t_bus_req r;
        r.cmd         = CMD_SET_LEN;
        r.shift_byte  = 8'($urandom);
        r.host_index  = 5'($urandom);
        r.host_byte   = 8'($urandom);
        r.host_length = len;
        send_req(r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input int unsigned idx, input logic [6:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= 1'(idx);
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_IDX_OWN_ADDR)
            own_addr = value;
        else
            wr_cap = value[5:0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_events();
        bus_event(CMD_STOP, 8'($urandom));   // stop with no start: no change
        bus_event(CMD_SHIFT, 8'hA5);         // shift while released
        bus_event(CMD_RSVD_LO, 8'($urandom));
        bus_event(CMD_RSVD_HI, 8'($urandom));
        set_read_len(6'(READ_DEPTH));
        set_read_len(6'(READ_DEPTH - 1));
    endtask

    // Every entry is loaded before any read can reach the store.
    task automatic test_read_store_load();
        for (int i = 0; i < READ_DEPTH; i++)
            load_byte(5'(i), (i == 0) ? 8'h00 : (i == READ_DEPTH - 1) ? 8'hFF : 8'($urandom));
    endtask

    task automatic test_general_call_write();
        bus_event(CMD_START, 8'($urandom));
        bus_event(CMD_SHIFT, GCALL_ADDR);
        bus_event(CMD_SHIFT, 8'($urandom));
        bus_event(CMD_SHIFT, 8'hFF);
        bus_event(CMD_SHIFT, 8'($urandom));
        bus_event(CMD_SHIFT, 8'h00);
        // Repeated start to a foreign address leaves the message open.
        bus_event(CMD_START, 8'($urandom));
        bus_event(CMD_SHIFT, 8'hFE);
        bus_event(CMD_STOP, 8'($urandom));
    endtask

    task automatic test_read_paths();
        write_reg(CFG_IDX_OWN_ADDR, 7'h7F);
        set_read_len(6'd1);
        bus_event(CMD_START, 8'($urandom));
        bus_event(CMD_SHIFT, {own_addr, RW_READ});
        bus_event(CMD_SHIFT, {7'($urandom), BUS_ACK});
        bus_event(CMD_SHIFT, 8'($urandom));
        // The length is used up, so the next read runs past it.
        bus_event(CMD_START, 8'($urandom));
        bus_event(CMD_SHIFT, {own_addr, RW_READ});
        bus_event(CMD_SHIFT, {7'($urandom), BUS_ACK});
        bus_event(CMD_SHIFT, 8'($urandom));
        bus_event(CMD_START, 8'($urandom));
        bus_event(CMD_SHIFT, {own_addr, RW_READ});
        bus_event(CMD_SHIFT, {7'($urandom), BUS_NACK});
        bus_event(CMD_STOP, 8'($urandom));
    endtask

    task automatic test_capacity_edges();
        write_reg(CFG_IDX_WR_CAP, 7'd0);
        bus_event(CMD_START, 8'($urandom));
        bus_event(CMD_SHIFT, {own_addr, RW_WRITE});
        write_reg(CFG_IDX_WR_CAP, 7'd1);
        bus_event(CMD_START, 8'($urandom));
        bus_event(CMD_SHIFT, {own_addr, RW_WRITE});
        bus_event(CMD_SHIFT, 8'($urandom));
        bus_event(CMD_SHIFT, 8'($urandom));
        bus_event(CMD_STOP, 8'($urandom));
    endtask

    task automatic run_random_traffic(input int n_items);
        int         stop_at;
        int         kind;
        int         pick;
        int         n_bytes;
        logic [7:0] addr;
        t_bus_req   r;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                pick = $urandom_range(99);
                addr = (pick < 75) ? {own_addr, RW_WRITE} :
                       (pick < 85) ? GCALL_ADDR : 8'($urandom);
                n_bytes = ($urandom_range(99) < 80) ? $urandom_range(0, 6)
                                                    : $urandom_range(0, WRITE_DEPTH + 2);
                bus_event(CMD_START, 8'($urandom));
                bus_event(CMD_SHIFT, addr);
                repeat (n_bytes) begin
                    bus_event(CMD_SHIFT, 8'($urandom));
                    bus_event(CMD_SHIFT, 8'($urandom));
                end
                // Otherwise the next start acts as a repeated start.
                if ($urandom_range(99) < 60)
                    bus_event(CMD_STOP, 8'($urandom));
            end else if (kind < 70) begin
                if ($urandom_range(1) != 0) begin
                    pick = $urandom_range(99);
                    set_read_len((pick < 20) ? 6'(READ_DEPTH) :
                                 (pick < 30) ? 6'd0 : 6'($urandom_range(1, 8)));
                end
                addr = ($urandom_range(99) < 85) ? {own_addr, RW_READ} : 8'($urandom);
                n_bytes = ($urandom_range(99) < 80) ? $urandom_range(0, 8)
                                                    : $urandom_range(0, READ_DEPTH + 2);
                bus_event(CMD_START, 8'($urandom));
                bus_event(CMD_SHIFT, addr);
                repeat (n_bytes) begin
                    bus_event(CMD_SHIFT, {7'($urandom),
                                          ($urandom_range(99) < 90) ? BUS_ACK : BUS_NACK});
                    bus_event(CMD_SHIFT, 8'($urandom));
                end
                if ($urandom_range(99) < 70)
                    bus_event(CMD_STOP, 8'($urandom));
            end else if (kind < 85) begin
                if ($urandom_range(1) != 0)
                    load_byte(5'($urandom), 8'($urandom));
                else
                    set_read_len(6'($urandom_range(0, READ_DEPTH)));
            end else begin
                r.cmd         = 3'($urandom_range(0, 7));
                r.shift_byte  = 8'($urandom);
                r.host_index  = 5'($urandom);
                r.host_byte   = 8'($urandom);
                r.host_length = 6'($urandom_range(0, READ_DEPTH));
                send_req(r);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [6:0] addr_set [6];
        logic [6:0] cap_set  [6];
        addr_set = '{7'h2A, 7'h7F, 7'h00, 7'h00, 7'h7F, 7'h00};
        cap_set  = '{7'd32, 7'd0, 7'd1, 7'd2, 7'd32, 7'd31};
        addr_set[3] = 7'($urandom);
        cap_set[3]  = 7'($urandom_range(2, 31));
        for (int i = 0; i < 6; i++) begin
            write_reg(CFG_IDX_OWN_ADDR, addr_set[i]);
            write_reg(CFG_IDX_WR_CAP, cap_set[i]);
            // One phase runs with both sides flat out.
            no_idle = (i == 4);
            run_random_traffic(PHASE_ITEMS);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_events();
        test_read_store_load();
        test_general_call_write();
        test_read_paths();
        test_capacity_edges();
        test_random_traffic();
        wait_drained();
        if (n_errors == 0) begin
            $display("** i2c_target_byte_engine_core: PASSED **");
        end else begin
            $display("** i2c_target_byte_engine_core: FAILED **");
        end
        $finish;
    end

endmodule
